[rtl/prdq_pkg.sv]
// ----------------------------------------------------------------------------
// prdq_pkg
// shared types and constants of the priority ready and delay queue
// ----------------------------------------------------------------------------
`default_nettype none

package prdq_pkg;

    // list geometry
    localparam int MaxTasks    = 16;
    localparam int MaxPriority = 8;
    localparam int IdxW        = $clog2(MaxTasks);
    localparam int CountW      = $clog2(MaxTasks + 1);

    // field widths
    localparam int IdW   = 8;
    localparam int PrioW = 4;
    localparam int TickW = 16;

    typedef enum logic [1:0] {
        MODE_ENQUEUE  = 2'd0,
        MODE_DISPATCH = 2'd1,
        MODE_RERUN    = 2'd2,
        MODE_NONE     = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_QUEUED      = 3'd0,
        STAT_DISPATCHED  = 3'd1,
        STAT_IDLE        = 3'd2,
        STAT_PRIO_REJECT = 3'd3,
        STAT_INVALID     = 3'd4,
        STAT_FULL        = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_INSERT,
        S_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    load;       // capture the input item
        logic    pos_first;  // insert position is the head
        logic    pos_second; // start scan after the head
        logic    pos_inc;    // advance scan position
        logic    insert;     // shift and write the selected list
        logic    pop;        // pop ready head into running task
        logic    res_load;   // load output register
        status_t res_code;
    } prdq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic invalid;     // negative delay or meaningless mode
        logic is_dispatch;
        logic is_delay;    // item goes to the delay list
        logic ready_empty;
        logic prio_bad;
        logic full;        // selected list is full
        logic head_first;  // new entry becomes the head
        logic scan_more;   // entry at scan position stays ahead
        logic out_free;    // output register can take a result
    } prdq_stat_t;

endpackage

`default_nettype wire

[rtl/prdq_ctrl.sv]
// ----------------------------------------------------------------------------
// prdq_ctrl
// command sequencer: decode, position scan, insert and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module prdq_ctrl
    import prdq_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire prdq_stat_t stat,
    output prdq_cmd_t       cmd,
    output state_t          state
);

    state_t  state_reg, state_next;
    status_t code_reg, code_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            code_reg  <= STAT_QUEUED;
        end else begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // next state and result code
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                state_next = S_RESULT;
                if (stat.invalid) begin
                    code_next = STAT_INVALID;
                end else if (stat.is_dispatch) begin
                    code_next = stat.ready_empty ? STAT_IDLE : STAT_DISPATCHED;
                end else if (!stat.is_delay && stat.prio_bad) begin
                    code_next = STAT_PRIO_REJECT;
                end else if (stat.full) begin
                    code_next = STAT_FULL;
                end else if (stat.head_first) begin
                    state_next = S_INSERT;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!stat.scan_more) begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT: begin
                code_next  = STAT_QUEUED;
                state_next = S_RESULT;
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb begin
        cmd          = '0;
        cmd.res_code = code_reg;
        s_ready      = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_DECODE: begin
                if (!stat.invalid) begin
                    if (stat.is_dispatch) begin
                        cmd.pop = !stat.ready_empty;
                    end else if ((stat.is_delay || !stat.prio_bad) && !stat.full) begin
                        cmd.pos_first  = stat.head_first;
                        cmd.pos_second = !stat.head_first;
                    end
                end
            end
            S_SCAN: begin
                cmd.pos_inc = stat.scan_more;
            end
            S_INSERT: begin
                cmd.insert = 1'b1;
            end
            S_RESULT: begin
                cmd.res_load = stat.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign state = state_reg;

endmodule

`default_nettype wire

[rtl/prdq_dp.sv]
// ----------------------------------------------------------------------------
// prdq_dp
// list storage, running task, scan compare and output register
// ----------------------------------------------------------------------------
`default_nettype none

module prdq_dp
    import prdq_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic [1:0]       s_mode,
    input  wire logic [IdW-1:0]   s_task_id,
    input  wire logic [PrioW-1:0] s_task_priority,
    input  wire logic [TickW-1:0] s_delay_ticks,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [2:0]            m_status,
    output logic [IdW-1:0]        m_out_task_id,
    output logic [PrioW-1:0]      m_out_priority,
    input  wire prdq_cmd_t        cmd,
    output prdq_stat_t            stat
);

    // captured item
    logic [1:0]       mode_reg;
    logic [IdW-1:0]   id_reg;
    logic [PrioW-1:0] prio_reg;
    logic [TickW-1:0] ticks_reg;

    // ready list
    logic [IdW-1:0]   rdy_id_reg   [MaxTasks];
    logic [PrioW-1:0] rdy_prio_reg [MaxTasks];
    logic [CountW-1:0] rdy_cnt_reg;

    // delay list
    logic [IdW-1:0]     dly_id_reg   [MaxTasks];
    logic [PrioW-1:0]   dly_prio_reg [MaxTasks];
    logic [TickW-2:0]   dly_tick_reg [MaxTasks];
    logic [CountW-1:0]  dly_cnt_reg;

    logic [IdW-1:0]    run_id_reg;
    logic [PrioW-1:0]  run_prio_reg;
    logic [CountW-1:0] pos_reg;

    logic             m_valid_reg;
    logic [2:0]       m_status_reg;
    logic [IdW-1:0]   m_id_reg;
    logic [PrioW-1:0] m_prio_reg;

    logic              is_delay;
    logic [IdW-1:0]    key_id;
    logic [PrioW-1:0]  key_prio;
    logic [TickW-2:0]  key_tick;
    logic [CountW-1:0] cnt;
    logic [IdxW-1:0]   scan_idx;

    assign is_delay = (mode_reg == MODE_RERUN) && (ticks_reg != '0) && !ticks_reg[TickW-1];
    assign key_id   = (mode_reg == MODE_ENQUEUE) ? id_reg : run_id_reg;
    assign key_prio = (mode_reg == MODE_ENQUEUE) ? prio_reg : run_prio_reg;
    assign key_tick = ticks_reg[TickW-2:0];
    assign cnt      = is_delay ? dly_cnt_reg : rdy_cnt_reg;
    assign scan_idx = pos_reg[IdxW-1:0];

    always_comb begin
        stat             = '0;
        stat.invalid     = (mode_reg == MODE_NONE)
                        || ((mode_reg == MODE_RERUN) && ticks_reg[TickW-1]);
        stat.is_dispatch = (mode_reg == MODE_DISPATCH);
        stat.is_delay    = is_delay;
        stat.ready_empty = (rdy_cnt_reg == '0);
        stat.prio_bad    = (key_prio > PrioW'(MaxPriority));
        stat.full        = (cnt == CountW'(MaxTasks));
        if (is_delay) begin
            stat.head_first = (cnt == '0) || (dly_tick_reg[0] > key_tick);
            stat.scan_more  = (pos_reg < cnt) && (dly_tick_reg[scan_idx] < key_tick);
        end else begin
            stat.head_first = (cnt == '0) || (rdy_prio_reg[0] < key_prio);
            stat.scan_more  = (pos_reg < cnt) && (rdy_prio_reg[scan_idx] > key_prio);
        end
        stat.out_free    = !m_valid_reg || m_ready;
    end

    // item capture and scan position
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mode_reg  <= s_mode;
            id_reg    <= s_task_id;
            prio_reg  <= s_task_priority;
            ticks_reg <= s_delay_ticks;
        end
        if (cmd.pos_first) begin
            pos_reg <= '0;
        end else if (cmd.pos_second) begin
            pos_reg <= CountW'(1);
        end else if (cmd.pos_inc) begin
            pos_reg <= pos_reg + CountW'(1);
        end
    end

    // list entries: each one takes its own neighbor or the new entry
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MaxTasks; i++) begin
            if (cmd.insert && !is_delay) begin
                if (CountW'(i) == pos_reg) begin
                    rdy_id_reg[i]   <= key_id;
                    rdy_prio_reg[i] <= key_prio;
                end else if ((i > 0) && (CountW'(i) > pos_reg)) begin
                    rdy_id_reg[i]   <= rdy_id_reg[(i > 0) ? i - 1 : 0];
                    rdy_prio_reg[i] <= rdy_prio_reg[(i > 0) ? i - 1 : 0];
                end
            end else if (cmd.pop && (i < MaxTasks - 1)) begin
                rdy_id_reg[i]   <= rdy_id_reg[(i < MaxTasks - 1) ? i + 1 : i];
                rdy_prio_reg[i] <= rdy_prio_reg[(i < MaxTasks - 1) ? i + 1 : i];
            end
            if (cmd.insert && is_delay) begin
                if (CountW'(i) == pos_reg) begin
                    dly_id_reg[i]   <= key_id;
                    dly_prio_reg[i] <= key_prio;
                    dly_tick_reg[i] <= key_tick;
                end else if ((i > 0) && (CountW'(i) > pos_reg)) begin
                    dly_id_reg[i]   <= dly_id_reg[(i > 0) ? i - 1 : 0];
                    dly_prio_reg[i] <= dly_prio_reg[(i > 0) ? i - 1 : 0];
                    dly_tick_reg[i] <= dly_tick_reg[(i > 0) ? i - 1 : 0];
                end
            end
        end
    end

    // control state: counts, running task, output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rdy_cnt_reg  <= '0;
            dly_cnt_reg  <= '0;
            run_id_reg   <= '0;
            run_prio_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cmd.insert && !is_delay) begin
                rdy_cnt_reg <= rdy_cnt_reg + CountW'(1);
            end else if (cmd.pop) begin
                rdy_cnt_reg <= rdy_cnt_reg - CountW'(1);
            end
            if (cmd.insert && is_delay) begin
                dly_cnt_reg <= dly_cnt_reg + CountW'(1);
            end
            if (cmd.pop) begin
                run_id_reg   <= rdy_id_reg[0];
                run_prio_reg <= rdy_prio_reg[0];
            end
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_status_reg <= cmd.res_code;
            if (cmd.res_code == STAT_DISPATCHED) begin
                m_id_reg   <= run_id_reg;
                m_prio_reg <= run_prio_reg;
            end else begin
                m_id_reg   <= '0;
                m_prio_reg <= '0;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_out_task_id  = m_id_reg;
    assign m_out_priority = m_prio_reg;

endmodule

`default_nettype wire

[rtl/priority_ready_and_delay_queue.sv]
// ----------------------------------------------------------------------------
// priority_ready_and_delay_queue
// scheduler queues: priority-sorted ready list and delay-sorted wait list
// ----------------------------------------------------------------------------
// One item is one command and gives exactly one result item. Items are
// handled one at a time: after the accept the sequencer decodes the command.
// Dispatch, reject, full and invalid commands go straight to the result
// state, an insert at the head goes through the insert state, and any other
// insert first steps over the entries after the head that stay ahead of it
// while the sequencer scans the chosen list one entry per cycle (at most 14
// entries), then inserts. An earlier result still waiting in the output
// register holds the sequencer in the result state. The next item is accepted
// in the cycle after the result is loaded into the output register, even
// while that result still waits to be taken. Both lists hold up to 16 entries
// in flip-flops; an insert shifts the whole tail down at once, a dispatch
// shifts the whole ready list up at once.
// There is no clearing pass after reset: only entries below the counts are
// ever read.
`default_nettype none

module priority_ready_and_delay_queue
    import prdq_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    // command items
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic [1:0]       s_mode,
    input  wire logic [IdW-1:0]   s_task_id,
    input  wire logic [PrioW-1:0] s_task_priority,
    input  wire logic [TickW-1:0] s_delay_ticks,
    // result items
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [2:0]            m_status,
    output logic [IdW-1:0]        m_out_task_id,
    output logic [PrioW-1:0]      m_out_priority
);

    prdq_cmd_t  cmd;
    prdq_stat_t stat;
    state_t     state;

    // sequencer: decode, scan, insert, hand result to the output register
    prdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd),
        .state   (state)
    );

    // lists, running task and output register
    prdq_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_mode          (s_mode),
        .s_task_id       (s_task_id),
        .s_task_priority (s_task_priority),
        .s_delay_ticks   (s_delay_ticks),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_task_id   (m_out_task_id),
        .m_out_priority  (m_out_priority),
        .cmd             (cmd),
        .stat            (stat)
    );

    // one item in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("item accepted while previous item in flight");

    // a result is loaded only at the end of an item
    a_load_in_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.res_load |-> (state == S_RESULT))
        else $error("result loaded outside result state");

    // a dispatched task always carries a legal priority
    a_disp_prio: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == STAT_DISPATCHED)) |-> (m_out_priority <= PrioW'(MaxPriority)))
        else $error("dispatched priority out of range");

    // non-dispatch results carry zero id and priority
    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != STAT_DISPATCHED))
            |-> ((m_out_task_id == '0) && (m_out_priority == '0)))
        else $error("non-dispatch result with task payload");

endmodule

`default_nettype wire

[dv/prdq_sched_checker.sv]
// ----------------------------------------------------------------------------
// prdq_sched_checker
// watches both channels of the scheduler queues, predicts each result item
// from its own copy of the ready and delay lists, and compares field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module prdq_sched_checker
    import prdq_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic [1:0]       s_mode,
    input  logic [IdW-1:0]   s_task_id,
    input  logic [PrioW-1:0] s_task_priority,
    input  logic [TickW-1:0] s_delay_ticks,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [2:0]       m_status,
    input  logic [IdW-1:0]   m_out_task_id,
    input  logic [PrioW-1:0] m_out_priority,
    output int               n_fail,
    output int               n_pending,
    output int               n_checked,
    output int               n_dispatch,
    output int               n_full
);

    typedef struct packed {
        status_t          status;
        logic [IdW-1:0]   id;
        logic [PrioW-1:0] prio;
    } sched_result_t;

    // predicted scheduler state
    logic [IdW-1:0]   rdy_id   [MaxTasks];
    logic [PrioW-1:0] rdy_prio [MaxTasks];
    int               rdy_cnt;
    logic [IdW-1:0]   dly_id   [MaxTasks];
    logic [PrioW-1:0] dly_prio [MaxTasks];
    logic [TickW-1:0] dly_tick [MaxTasks];
    int               dly_cnt;
    logic [IdW-1:0]   run_id;
    logic [PrioW-1:0] run_prio;

    sched_result_t sched_expected_q[$];
    sched_result_t cmd_res;
    sched_result_t want;

    int fail_cnt     = 0;
    int checked_cnt  = 0;
    int dispatch_cnt = 0;
    int full_cnt     = 0;
    int pending_cnt  = 0;

    assign n_fail     = fail_cnt;
    assign n_pending  = pending_cnt;
    assign n_checked  = checked_cnt;
    assign n_dispatch = dispatch_cnt;
    assign n_full     = full_cnt;

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_cnt++;
    endtask

    // priority-sorted insert; equal priority never passes the head
    task automatic ready_insert(input logic [IdW-1:0] id, input logic [PrioW-1:0] prio,
                                output status_t st);
        int pos;
        if (prio > MaxPriority) begin
            st = STAT_PRIO_REJECT;
        end else if (rdy_cnt >= MaxTasks) begin
            st = STAT_FULL;
        end else begin
            if (rdy_cnt == 0 || rdy_prio[0] < prio) begin
                pos = 0;
            end else begin
                pos = 1;
                while (pos < rdy_cnt && rdy_prio[pos] > prio)
                    pos++;
            end
            for (int i = rdy_cnt; i > pos; i--) begin
                rdy_id[i]   = rdy_id[i-1];
                rdy_prio[i] = rdy_prio[i-1];
            end
            rdy_id[pos]   = id;
            rdy_prio[pos] = prio;
            rdy_cnt++;
            st = STAT_QUEUED;
        end
    endtask

    task automatic sched_predict(input mode_t mode, input logic [IdW-1:0] id,
                                 input logic [PrioW-1:0] prio,
                                 input logic [TickW-1:0] ticks,
                                 output sched_result_t res);
        int pos;
        status_t st;
        res = '{status: STAT_INVALID, id: '0, prio: '0};
        case (mode)
            MODE_ENQUEUE: begin
                ready_insert(id, prio, st);
                res.status = st;
            end
            MODE_DISPATCH: begin
                if (rdy_cnt == 0) begin
                    res.status = STAT_IDLE;
                end else begin
                    run_id   = rdy_id[0];
                    run_prio = rdy_prio[0];
                    for (int i = 1; i < rdy_cnt; i++) begin
                        rdy_id[i-1]   = rdy_id[i];
                        rdy_prio[i-1] = rdy_prio[i];
                    end
                    rdy_cnt--;
                    res = '{status: STAT_DISPATCHED, id: run_id, prio: run_prio};
                end
            end
            MODE_RERUN: begin
                if (ticks == '0) begin
                    ready_insert(run_id, run_prio, st);
                    res.status = st;
                end else if (ticks[TickW-1]) begin
                    res.status = STAT_INVALID;
                end else if (dly_cnt >= MaxTasks) begin
                    res.status = STAT_FULL;
                end else begin
                    // ascending delay order, same head rule as the ready list
                    if (dly_cnt == 0 || dly_tick[0] > ticks) begin
                        pos = 0;
                    end else begin
                        pos = 1;
                        while (pos < dly_cnt && dly_tick[pos] < ticks)
                            pos++;
                    end
                    for (int i = dly_cnt; i > pos; i--) begin
                        dly_id[i]   = dly_id[i-1];
                        dly_prio[i] = dly_prio[i-1];
                        dly_tick[i] = dly_tick[i-1];
                    end
                    dly_id[pos]   = run_id;
                    dly_prio[pos] = run_prio;
                    dly_tick[pos] = ticks;
                    dly_cnt++;
                    res.status = STAT_QUEUED;
                end
            end
            default: res.status = STAT_INVALID;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            rdy_cnt  = 0;
            dly_cnt  = 0;
            run_id   = '0;
            run_prio = '0;
            sched_expected_q.delete();
        end else begin
            if (s_valid && s_ready) begin
                sched_predict(mode_t'(s_mode), s_task_id, s_task_priority, s_delay_ticks,
                              cmd_res);
                sched_expected_q.push_back(cmd_res);
            end
            if (m_valid && m_ready) begin
                if (sched_expected_q.size() == 0) begin
                    report_mismatch($sformatf("result with no command waiting, status %0d",
                                              m_status));
                end else begin
                    want = sched_expected_q.pop_front();
                    checked_cnt++;
                    if (want.status == STAT_DISPATCHED)
                        dispatch_cnt++;
                    if (want.status == STAT_FULL)
                        full_cnt++;
                    if (m_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d (result %0d)",
                                                  m_status, want.status, checked_cnt));
                    if (m_out_task_id !== want.id)
                        report_mismatch($sformatf("task id %0d, expected %0d (result %0d)",
                                                  m_out_task_id, want.id, checked_cnt));
                    if (m_out_priority !== want.prio)
                        report_mismatch($sformatf("priority %0d, expected %0d (result %0d)",
                                                  m_out_priority, want.prio, checked_cnt));
                end
            end
        end
        pending_cnt = sched_expected_q.size();
    end

endmodule

[dv/tb_priority_ready_and_delay_queue.sv]
// ----------------------------------------------------------------------------
// tb_priority_ready_and_delay_queue
// drives scheduler commands with random gaps and back-pressure; a checker
// beside the block predicts every result item and counts mismatches
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_priority_ready_and_delay_queue;

    import prdq_pkg::*;

    localparam int RandomItems = 500;
    localparam int IdlePct     = 29;
    localparam int HoldCycles  = 250;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic [1:0]       s_mode;
    logic [IdW-1:0]   s_task_id;
    logic [PrioW-1:0] s_task_priority;
    logic [TickW-1:0] s_delay_ticks;
    logic             m_valid;
    logic             m_ready;
    logic [2:0]       m_status;
    logic [IdW-1:0]   m_out_task_id;
    logic [PrioW-1:0] m_out_priority;

    int n_fail;
    int n_pending;
    int n_checked;
    int n_dispatch;
    int n_full;

    // stimulus bookkeeping
    int sent_cnt  = 0;
    int n_enq     = 0;
    int n_disp    = 0;
    int n_rerun   = 0;
    int n_other   = 0;
    bit calm      = 1'b0;   // no idling on either side while set
    bit held      = 1'b0;
    int hold_left = 0;

    priority_ready_and_delay_queue i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_task_id       (s_task_id),
        .s_task_priority (s_task_priority),
        .s_delay_ticks   (s_delay_ticks),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_task_id   (m_out_task_id),
        .m_out_priority  (m_out_priority)
    );

    prdq_sched_checker i_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_task_id       (s_task_id),
        .s_task_priority (s_task_priority),
        .s_delay_ticks   (s_delay_ticks),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_out_task_id   (m_out_task_id),
        .m_out_priority  (m_out_priority),
        .n_fail          (n_fail),
        .n_pending       (n_pending),
        .n_checked       (n_checked),
        .n_dispatch      (n_dispatch),
        .n_full          (n_full)
    );

    // 10 ns clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // hard stop well past the slowest legal run
    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    // offer one command item and hold it until accepted; random gaps first
    task automatic send_cmd(input mode_t m, input logic [IdW-1:0] id,
                            input logic [PrioW-1:0] prio, input logic [TickW-1:0] ticks);
        @(negedge aclk);
        while (!calm && $urandom_range(99) < IdlePct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_mode          <= m;
        s_task_id       <= id;
        s_task_priority <= prio;
        s_delay_ticks   <= ticks;
        do
            @(posedge aclk);
        while (!s_ready);
        sent_cnt++;
        case (m)
            MODE_ENQUEUE:  n_enq++;
            MODE_DISPATCH: n_disp++;
            MODE_RERUN:    n_rerun++;
            default:       n_other++;
        endcase
    endtask

    // random command; fill phases push the ready list toward full,
    // drain phases empty it so idle dispatches show up too
    task automatic random_cmd(input bit fill);
        int r;
        int k;
        mode_t m;
        logic [PrioW-1:0] prio;
        logic [TickW-1:0] ticks;
        r = $urandom_range(99);
        if (r < (fill ? 55 : 15))
            m = MODE_ENQUEUE;
        else if (r < 70)
            m = MODE_DISPATCH;
        else if (r < 97)
            m = MODE_RERUN;
        else
            m = MODE_NONE;

        // priorities bunched on a few values so equal-priority placement is hit often
        k = $urandom_range(99);
        if (k < 15)
            prio = PrioW'($urandom_range(15, MaxPriority + 1));
        else if (k < 55)
            prio = PrioW'($urandom_range(4, 2));
        else
            prio = PrioW'($urandom_range(MaxPriority, 0));

        k = $urandom_range(99);
        if (k < 40)
            ticks = '0;
        else if (k < 55)
            ticks = {1'b1, 15'($urandom)};
        else if (k < 62)
            ticks = 16'd1;
        else if (k < 69)
            ticks = 16'h7fff;
        else
            ticks = {1'b0, 15'($urandom)};
        send_cmd(m, IdW'($urandom), prio, ticks);
    endtask

    // result side: random stalls, one long hold-off so the block backs up
    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (!held && sent_cnt >= 320) begin
                held      = 1'b1;
                hold_left = HoldCycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || ($urandom_range(99) >= IdlePct);
            end
        end
    end

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_mode          = MODE_ENQUEUE;
        s_task_id       = '0;
        s_task_priority = '0;
        s_delay_ticks   = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty list and the reset running task
        send_cmd(MODE_DISPATCH, 8'd7, 4'd3, 16'd0);       // idle
        send_cmd(MODE_RERUN, 8'd9, 4'd9, 16'd0);          // re-queues id 0 priority 0
        send_cmd(MODE_DISPATCH, 8'd0, 4'd0, 16'd0);       // takes it back out
        // delay list and bad delays
        send_cmd(MODE_RERUN, 8'd0, 4'd0, 16'h7fff);
        send_cmd(MODE_RERUN, 8'd0, 4'd0, 16'd1);          // new delay head
        send_cmd(MODE_RERUN, 8'hff, 4'hf, 16'h8000);      // most negative delay
        send_cmd(MODE_NONE, 8'hff, 4'hf, 16'hffff);       // meaningless mode
        send_cmd(MODE_ENQUEUE, 8'hff, 4'hf, 16'd0);       // priority rejected
        // equal priorities: second one stays behind the head, third goes ahead of second
        send_cmd(MODE_ENQUEUE, 8'hff, 4'(MaxPriority), 16'd0);
        send_cmd(MODE_ENQUEUE, 8'd1, 4'(MaxPriority), 16'd0);
        send_cmd(MODE_ENQUEUE, 8'd2, 4'(MaxPriority), 16'd0);
        send_cmd(MODE_ENQUEUE, 8'd0, 4'd0, 16'd0);
        send_cmd(MODE_ENQUEUE, 8'd3, 4'd5, 16'd0);
        // fill the ready list to the brim
        for (int i = 0; i < MaxTasks - 5; i++)
            send_cmd(MODE_ENQUEUE, 8'(16 + i), 4'($urandom_range(MaxPriority, 0)),
                     16'($urandom));
        send_cmd(MODE_ENQUEUE, 8'd99, 4'd4, 16'd0);       // full
        send_cmd(MODE_ENQUEUE, 8'd98, 4'(MaxPriority + 1), 16'd0); // reject beats full
        send_cmd(MODE_RERUN, 8'd0, 4'd0, 16'd0);          // full via re-run

        for (int i = 0; i < RandomItems; i++) begin
            calm = (i >= 100 && i < 200);
            random_cmd(((i / 40) % 2) == 0);
        end
        calm = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;

        // drain, then wait for any stray result
        wait (n_pending == 0);
        repeat (40) @(posedge aclk);

        $display("covered %0d commands: %0d enqueue, %0d dispatch, %0d re-run, %0d no-op",
                 sent_cnt, n_enq, n_disp, n_rerun, n_other);
        $display("checked %0d results, %0d dispatched tasks, %0d list-full answers",
                 n_checked, n_dispatch, n_full);
        if (n_fail == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
